[rtl/compass_heading_with_glitch_hold_macros.svh]
// ----------------------------------------------------------------------------
// Compass heading assertion macros
// Concurrent checks clocked on clk_i, with and without the reset gate.
// ----------------------------------------------------------------------------
`ifndef COMPASS_HEADING_WITH_GLITCH_HOLD_MACROS_SVH
`define COMPASS_HEADING_WITH_GLITCH_HOLD_MACROS_SVH

// check once out of reset
`define CHWGH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every edge, reset included
`define CHWGH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/chwgh_pkg.sv]
// ----------------------------------------------------------------------------
// Compass heading package
// Types, constants and the arctangent table shared by the heading block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chwgh_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned SampleBitsDef  = 16;

  localparam int unsigned HeadingW = 15;
  localparam int unsigned AngleW   = 24;
  localparam int unsigned AtanLen  = 24;
  localparam int unsigned AtanIdxW = 5;

  localparam logic [HeadingW-1:0] MinAngleRst   = 15'd64;
  localparam logic [HeadingW-1:0] HalfCircleOut = 15'd11520;
  localparam logic [HeadingW:0]   FullCircleOut = 16'd23040;

  localparam logic signed [AngleW-1:0] HalfCircleFine = 24'sd2949120;
  localparam logic signed [AngleW-1:0] FullCircleFine = 24'sd5898240;
  localparam logic [AngleW-1:0]        RoundHalf      = 24'd128;

  // atan(2^-i) in 1/16384 degree
  localparam logic signed [AngleW-1:0] AtanFine [AtanLen] = '{
    24'sd737280, 24'sd435242, 24'sd229970, 24'sd116736,
    24'sd58595,  24'sd29326,  24'sd14667,  24'sd7334,
    24'sd3667,   24'sd1833,   24'sd917,    24'sd458,
    24'sd229,    24'sd115,    24'sd57,     24'sd29,
    24'sd14,     24'sd7,      24'sd4,      24'sd2,
    24'sd1,      24'sd0,      24'sd0,      24'sd0
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_NORM,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic busy;
    logic last;
  } cordic_stat_t;

endpackage

[rtl/chwgh_in_if.sv]
// ----------------------------------------------------------------------------
// Compass heading sample channel
// Valid/ready channel carrying one signed magnetometer pair per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface chwgh_in_if #(
  parameter int unsigned SampleBits = chwgh_pkg::SampleBitsDef
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] mag_x;
  logic signed [SampleBits-1:0] mag_y;

  modport source (output valid, output mag_x, output mag_y, input ready);
  modport sink   (input valid, input mag_x, input mag_y, output ready);
endinterface

[rtl/chwgh_out_if.sv]
// ----------------------------------------------------------------------------
// Compass heading result channel
// Valid/ready channel carrying the held bearing and the update flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface chwgh_out_if;
  logic                            valid;
  logic                            ready;
  logic [chwgh_pkg::HeadingW-1:0]  heading;
  logic                            updated;

  modport source (output valid, output heading, output updated, input ready);
  modport sink   (input valid, input heading, input updated, output ready);
endinterface

[rtl/chwgh_cordic.sv]
// ----------------------------------------------------------------------------
// Compass heading CORDIC engine
// Vectoring CORDIC, one micro-rotation per cycle through a shared shift unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chwgh_cordic #(
  parameter int unsigned CordicSteps = chwgh_pkg::CordicStepsDef,
  parameter int unsigned SampleBits  = chwgh_pkg::SampleBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [SampleBits-1:0]          mag_x_i,
  input  logic signed [SampleBits-1:0]          mag_y_i,
  output logic signed [chwgh_pkg::AngleW-1:0]   z_o,
  output chwgh_pkg::cordic_stat_t               stat_o
);

  localparam int unsigned DataW = SampleBits + 11;
  localparam int unsigned StepW = (CordicSteps > 1) ? $clog2(CordicSteps) : 1;
  localparam int unsigned IdxW  = chwgh_pkg::AtanIdxW;
  localparam logic [StepW-1:0] LastStep = StepW'(CordicSteps - 1);

  logic signed [DataW-1:0] x_q, x_d, y_q, y_d;
  logic signed [DataW-1:0] xs, ys, dx, dy;
  logic signed [chwgh_pkg::AngleW-1:0] z_q, z_d, atan;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic [IdxW-1:0]  idx;
  logic             last;

  assign xs   = DataW'(mag_x_i) <<< 8;
  assign ys   = DataW'(mag_y_i) <<< 8;
  assign dx   = y_q >>> step_q;
  assign dy   = x_q >>> step_q;
  assign idx  = IdxW'(step_q);
  assign atan = chwgh_pkg::AtanFine[idx];
  assign last = busy_q && (step_q == LastStep);

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      // fold the left half-plane onto the right
      if (mag_x_i[SampleBits-1]) begin
        x_d = -xs;
        y_d = -ys;
        z_d = chwgh_pkg::HalfCircleFine;
      end else begin
        x_d = xs;
        y_d = ys;
        z_d = '0;
      end
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!y_q[DataW-1]) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan;
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan;
      end
      if (last) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign z_o         = z_q;
  assign stat_o.busy = busy_q;
  assign stat_o.last = last;

endmodule

[rtl/compass_heading_with_glitch_hold.sv]
// ----------------------------------------------------------------------------
// Compass heading with glitch hold
// Magnetometer bearing by CORDIC, gated by a threshold, last good value held.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one signed (mag_x, mag_y) pair per word; out_o returns one
//   word per sample: the held bearing in 1/64 degree and an updated flag.
//   cfg_wr_en_i / cfg_wr_data_i write the acceptance threshold; write it only
//   while no sample is in flight.
//   Sequence: a sample is taken in IDLE, ITER runs the CORDIC, NORM wraps
//   and rounds the angle, DECIDE writes the output register; samples with
//   mag_y zero (the zero vector included) skip ITER and NORM.
//   Flow: one sample at a time, through the single CORDIC engine doing one
//   micro-rotation per cycle; in_i.ready is high only while the sequencer
//   is idle.
//   Reset: held bearing clears to 0, threshold returns to 1 degree (64), the
//   output register empties.
//   Stall: a result waits in the output register; the next sample is taken
//   meanwhile, and its result waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "compass_heading_with_glitch_hold_macros.svh"

module compass_heading_with_glitch_hold #(
  parameter int unsigned CORDIC_STEPS = chwgh_pkg::CordicStepsDef,
  parameter int unsigned SAMPLE_BITS  = chwgh_pkg::SampleBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_wr_en_i,
  input  logic [chwgh_pkg::HeadingW-1:0] cfg_wr_data_i,
  chwgh_in_if.sink                       in_i,
  chwgh_out_if.source                    out_o
);

  localparam int unsigned HW = chwgh_pkg::HeadingW;
  localparam int unsigned AW = chwgh_pkg::AngleW;

  chwgh_pkg::state_e state_q, state_d;
  chwgh_pkg::cordic_stat_t cstat;

  logic signed [AW-1:0] z;
  logic [AW-1:0]        z_pos, z_rnd;
  logic [HW:0]          b_rnd;
  logic [HW-1:0]        min_angle_q;
  logic [HW-1:0]        bearing_q, bearing_d;
  logic                 bvalid_q, bvalid_d;
  logic [HW-1:0]        held_q, held_d;
  logic                 accept;
  logic                 in_fire, axis, start, slot_free, decide_fire;
  logic                 out_valid_q;
  logic [HW-1:0]        out_heading_q;
  logic                 out_updated_q;

  chwgh_cordic #(
    .CordicSteps (CORDIC_STEPS),
    .SampleBits  (SAMPLE_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mag_x_i (in_i.mag_x),
    .mag_y_i (in_i.mag_y),
    .z_o     (z),
    .stat_o  (cstat)
  );

  assign in_fire   = in_i.valid && in_i.ready;
  assign axis      = (in_i.mag_y == '0);
  assign slot_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      chwgh_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = axis ? chwgh_pkg::ST_DECIDE : chwgh_pkg::ST_ITER;
        end
      end
      chwgh_pkg::ST_ITER: begin
        if (cstat.last) begin
          state_d = chwgh_pkg::ST_NORM;
        end
      end
      chwgh_pkg::ST_NORM:   state_d = chwgh_pkg::ST_DECIDE;
      chwgh_pkg::ST_DECIDE: begin
        if (slot_free) begin
          state_d = chwgh_pkg::ST_IDLE;
        end
      end
      default: state_d = chwgh_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_i.ready  = 1'b0;
    start       = 1'b0;
    decide_fire = 1'b0;
    case (state_q)
      chwgh_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        start      = in_i.valid && !axis;
      end
      chwgh_pkg::ST_DECIDE: decide_fire = slot_free;
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  // wrap to one turn and round to 1/64 degree
  assign z_pos = z[AW-1] ? AW'(z + chwgh_pkg::FullCircleFine) : AW'(z);
  assign z_rnd = z_pos + chwgh_pkg::RoundHalf;
  assign b_rnd = (HW + 1)'(z_rnd >> 8);

  always_comb begin
    bearing_d = bearing_q;
    bvalid_d  = bvalid_q;
    if (state_q == chwgh_pkg::ST_IDLE && in_fire) begin
      bvalid_d  = !(axis && (in_i.mag_x == '0));
      bearing_d = in_i.mag_x[SAMPLE_BITS-1] ? chwgh_pkg::HalfCircleOut : '0;
    end else if (state_q == chwgh_pkg::ST_NORM) begin
      bvalid_d  = 1'b1;
      bearing_d = (b_rnd >= chwgh_pkg::FullCircleOut) ? '0 : b_rnd[HW-1:0];
    end
  end

  assign accept = bvalid_q && (bearing_q > min_angle_q)
                  && ({1'b0, bearing_q} <= chwgh_pkg::FullCircleOut);
  assign held_d = accept ? bearing_q : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chwgh_pkg::ST_IDLE;
      min_angle_q <= chwgh_pkg::MinAngleRst;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) begin
        min_angle_q <= cfg_wr_data_i;
      end
      if (decide_fire) begin
        held_q      <= held_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bearing_q <= bearing_d;
    bvalid_q  <= bvalid_d;
    if (decide_fire) begin
      out_heading_q <= held_d;
      out_updated_q <= accept;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.heading = out_heading_q;
  assign out_o.updated = out_updated_q;

  `CHWGH_ASSERT(a_one_in_flight, in_fire |=> !in_i.ready, "second sample taken while busy")
  `CHWGH_ASSERT(a_held_on_write, !$stable(held_q) |-> $past(decide_fire), "held bearing moved")
  `CHWGH_ASSERT(a_out_is_held, out_o.valid |-> (out_o.heading == held_q), "result not held")
  `CHWGH_ASSERT_ALWAYS(a_last_in_iter, cstat.last |-> (state_q == chwgh_pkg::ST_ITER), "stray end")

endmodule
